### rtl/core/top_k_word_insertion_list_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the top-k word insertion list core
// Clocked on clk_i, disabled while rst_ni is low; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef TOP_K_WORD_INSERTION_LIST_CORE_DEFINES_SVH
`define TOP_K_WORD_INSERTION_LIST_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Check that a property holds at every clock edge out of reset.
`define TKWL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition never occurs out of reset.
`define TKWL_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define TKWL_ASSERT(lbl, prop, msg)
`define TKWL_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

### rtl/core/tkwl_pkg.sv
// ----------------------------------------------------------------------------
// tkwl_pkg
// Types, codes and defaults shared by the top-k word insertion list core.
// ----------------------------------------------------------------------------
package tkwl_pkg;

  localparam int LIST_ENTRIES_DEF  = 16;
  localparam int WORD_CAPACITY_DEF = 48;
  localparam int QUEUE_DEPTH       = 2;

  // Operation codes of the input word
  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Report kinds of the result word
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  typedef struct packed {
    logic [1:0]  operation;
    logic [20:0] code_point;
    logic        last;
    logic [7:0]  probability;
    logic [3:0]  read_slot;
    logic [5:0]  read_offset;
  } in_word_t;

  typedef struct packed {
    logic        report_kind;
    logic        inserted;
    logic [3:0]  insert_slot;
    logic [20:0] entry_code_point;
    logic [5:0]  entry_length;
    logic [7:0]  entry_probability;
  } out_word_t;

  typedef enum logic [1:0] {
    CMD_PUSH,
    CMD_LAST,
    CMD_READ,
    CMD_CLEAR
  } cmd_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [20:0] code_point;
    logic [7:0]  probability;
    logic [3:0]  read_slot;
    logic [5:0]  read_offset;
  } cmd_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_READ,
    ST_RDOUT
  } state_e;

endpackage

### rtl/core/tkwl_front.sv
// ----------------------------------------------------------------------------
// tkwl_front
// Accepts input words, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
`include "top_k_word_insertion_list_core_defines.svh"

module tkwl_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  tkwl_pkg::in_word_t  in_word_i,
  output logic                head_valid_o,
  output tkwl_pkg::cmd_word_t head_o,
  input  logic                pop_i
);

  localparam int QPW = (tkwl_pkg::QUEUE_DEPTH > 1) ? $clog2(tkwl_pkg::QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(tkwl_pkg::QUEUE_DEPTH + 1);

  tkwl_pkg::cmd_word_t ent_q [tkwl_pkg::QUEUE_DEPTH];
  logic [QPW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [QPW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0]      cnt_q, cnt_d;
  logic                full;
  logic                enq;
  logic                deq;
  tkwl_pkg::cmd_word_t cls;

  assign full = (32'(cnt_q) == tkwl_pkg::QUEUE_DEPTH);
  assign busy = full;

  // Classify the word; drop the unused operation code at the door
  always_comb begin
    cls.code_point  = in_word_i.code_point;
    cls.probability = in_word_i.probability;
    cls.read_slot   = in_word_i.read_slot;
    cls.read_offset = in_word_i.read_offset;
    cls.cmd         = tkwl_pkg::CMD_PUSH;
    enq             = start && !full;
    unique case (in_word_i.operation)
      tkwl_pkg::OP_PUSH:  cls.cmd = in_word_i.last ? tkwl_pkg::CMD_LAST : tkwl_pkg::CMD_PUSH;
      tkwl_pkg::OP_READ:  cls.cmd = tkwl_pkg::CMD_READ;
      tkwl_pkg::OP_CLEAR: cls.cmd = tkwl_pkg::CMD_CLEAR;
      default:            enq     = 1'b0;
    endcase
  end

  assign deq          = pop_i && (cnt_q != '0);
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = ent_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (enq) begin
      wr_ptr_d = (32'(wr_ptr_q) == tkwl_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
    end
    if (deq) begin
      rd_ptr_d = (32'(rd_ptr_q) == tkwl_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
    end
    if (enq && !deq) begin
      cnt_d = cnt_q + 1'b1;
    end else if (deq && !enq) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Hold queued words
  always_ff @(posedge clk_i) begin
    if (enq) begin
      ent_q[wr_ptr_q] <= cls;
    end
  end

  `TKWL_ASSERT(a_queue_bound, 32'(cnt_q) <= tkwl_pkg::QUEUE_DEPTH, "queue count overflow")

endmodule

### rtl/core/tkwl_back.sv
// ----------------------------------------------------------------------------
// tkwl_back
// Executes queued commands: buffers candidates, searches ranks, shifts the
// list, serves reads and clears it. Words live in a row memory addressed through a
// per-rank row pointer, so an insertion moves pointers and not words.
// ----------------------------------------------------------------------------
`include "top_k_word_insertion_list_core_defines.svh"

module tkwl_back #(
  parameter int ListEntries  = tkwl_pkg::LIST_ENTRIES_DEF,
  parameter int WordCapacity = tkwl_pkg::WORD_CAPACITY_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  tkwl_pkg::cmd_word_t head_i,
  output logic                pop_o,
  output logic                result_valid_o,
  output tkwl_pkg::out_word_t result_o
);

  localparam int Rows = ListEntries + 1;
  localparam int IW   = (ListEntries > 1) ? $clog2(ListEntries) : 1;
  localparam int PW   = $clog2(Rows);
  localparam int LW   = $clog2(WordCapacity + 1);
  localparam int AW   = (Rows * WordCapacity > 1) ? $clog2(Rows * WordCapacity) : 1;

  tkwl_pkg::state_e state_q, state_d;

  logic [7:0]    prob_q [ListEntries];
  logic [LW-1:0] len_q  [ListEntries];
  logic [PW-1:0] ptr_q  [ListEntries];
  logic [PW-1:0] spare_q, spare_d;
  logic [LW-1:0] cnt_q, cnt_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [7:0]    cand_prob_q, cand_prob_d;
  logic [LW-1:0] cand_len_q, cand_len_d;
  logic [5:0]    off_q, off_d;
  logic          rd_ok_q, rd_ok_d;
  logic          rd_hit_q, rd_hit_d;
  logic [LW-1:0] rd_len_q, rd_len_d;
  logic [7:0]    rd_prob_q, rd_prob_d;

  logic [20:0]   mem_q [Rows * WordCapacity];
  logic [20:0]   rd_data_q;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic          room;
  logic          hit;
  logic          ins_en;
  logic          clr_en;

  logic                result_valid_q, result_valid_d;
  tkwl_pkg::out_word_t result_q, result_d;

  assign room    = (32'(cnt_q) < WordCapacity);
  assign wr_addr = AW'(32'(spare_q) * WordCapacity + 32'(cnt_q));
  assign rd_addr = AW'(32'(ptr_q[idx_q]) * WordCapacity + 32'(off_q));
  assign hit     = (cand_prob_q > prob_q[idx_q]) ||
                   ((cand_prob_q == prob_q[idx_q]) && (cand_len_q < len_q[idx_q]));

  // Sequence commands
  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    idx_d          = idx_q;
    spare_d        = spare_q;
    cand_prob_d    = cand_prob_q;
    cand_len_d     = cand_len_q;
    off_d          = off_q;
    rd_ok_d        = rd_ok_q;
    rd_hit_d       = rd_hit_q;
    rd_len_d       = rd_len_q;
    rd_prob_d      = rd_prob_q;
    pop_o          = 1'b0;
    wr_en          = 1'b0;
    ins_en         = 1'b0;
    clr_en         = 1'b0;
    result_valid_d = 1'b0;
    result_d       = '0;
    unique case (state_q)
      tkwl_pkg::ST_IDLE: begin
        if (head_valid_i) begin
          pop_o = 1'b1;
          unique case (head_i.cmd)
            tkwl_pkg::CMD_PUSH: begin
              wr_en = room;
              cnt_d = cnt_q + LW'(room);
            end
            tkwl_pkg::CMD_LAST: begin
              wr_en       = room;
              cand_len_d  = cnt_q + LW'(room);
              cand_prob_d = head_i.probability;
              cnt_d       = '0;
              idx_d       = '0;
              state_d     = tkwl_pkg::ST_SEARCH;
            end
            tkwl_pkg::CMD_READ: begin
              idx_d   = IW'(head_i.read_slot);
              rd_ok_d = (32'(head_i.read_slot) < ListEntries);
              off_d   = head_i.read_offset;
              state_d = tkwl_pkg::ST_READ;
            end
            tkwl_pkg::CMD_CLEAR: begin
              clr_en = 1'b1;
              cnt_d  = '0;
            end
            default: ;
          endcase
        end
      end
      tkwl_pkg::ST_SEARCH: begin
        // Test one rank per cycle; insert at the first that loses
        if (hit) begin
          ins_en                     = 1'b1;
          spare_d                    = ptr_q[ListEntries-1];
          result_valid_d             = 1'b1;
          result_d.report_kind       = tkwl_pkg::KIND_INSERT;
          result_d.inserted          = 1'b1;
          result_d.insert_slot       = 4'(idx_q);
          state_d                    = tkwl_pkg::ST_IDLE;
        end else if (32'(idx_q) == ListEntries - 1) begin
          result_valid_d             = 1'b1;
          result_d.report_kind       = tkwl_pkg::KIND_INSERT;
          state_d                    = tkwl_pkg::ST_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      tkwl_pkg::ST_READ: begin
        rd_hit_d  = rd_ok_q && (32'(off_q) < 32'(len_q[idx_q]));
        rd_len_d  = rd_ok_q ? len_q[idx_q]  : '0;
        rd_prob_d = rd_ok_q ? prob_q[idx_q] : '0;
        state_d   = tkwl_pkg::ST_RDOUT;
      end
      tkwl_pkg::ST_RDOUT: begin
        result_valid_d             = 1'b1;
        result_d.report_kind       = tkwl_pkg::KIND_READ;
        result_d.entry_code_point  = rd_hit_q ? rd_data_q : '0;
        result_d.entry_length      = 6'(rd_len_q);
        result_d.entry_probability = rd_prob_q;
        state_d                    = tkwl_pkg::ST_IDLE;
      end
      default: state_d = tkwl_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= tkwl_pkg::ST_IDLE;
      cnt_q          <= '0;
      idx_q          <= '0;
      spare_q        <= PW'(ListEntries);
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      cnt_q          <= cnt_d;
      idx_q          <= idx_d;
      spare_q        <= spare_d;
      result_valid_q <= result_valid_d;
    end
  end

  // Hold command operands and the result word
  always_ff @(posedge clk_i) begin
    cand_prob_q <= cand_prob_d;
    cand_len_q  <= cand_len_d;
    off_q       <= off_d;
    rd_ok_q     <= rd_ok_d;
    rd_hit_q    <= rd_hit_d;
    rd_len_q    <= rd_len_d;
    rd_prob_q   <= rd_prob_d;
    result_q    <= result_d;
  end

  // Shift ranks down on insert; clear empties the list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ListEntries; i++) begin
        prob_q[i] <= '0;
        len_q[i]  <= '0;
        ptr_q[i]  <= PW'(i);
      end
    end else if (clr_en) begin
      for (int i = 0; i < ListEntries; i++) begin
        prob_q[i] <= '0;
        len_q[i]  <= '0;
      end
    end else if (ins_en) begin
      for (int i = ListEntries - 1; i > 0; i--) begin
        if (32'(idx_q) < i) begin
          prob_q[i] <= prob_q[i-1];
          len_q[i]  <= len_q[i-1];
          ptr_q[i]  <= ptr_q[i-1];
        end
      end
      prob_q[idx_q] <= cand_prob_q;
      len_q[idx_q]  <= cand_len_q;
      ptr_q[idx_q]  <= spare_q;
    end
  end

  // Word memory: candidate writes into the spare row, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= head_i.code_point;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  `TKWL_ASSERT(a_cnt_bound, 32'(cnt_q) <= WordCapacity, "candidate count past capacity")
  `TKWL_ASSERT(a_spare_free, spare_q != ptr_q[0], "spare row aliases top rank")
  `TKWL_ASSERT(a_read_reports, state_q == tkwl_pkg::ST_RDOUT |=> result_valid_o, "read lost")

endmodule

### rtl/core/top_k_word_insertion_list_core.sv
// ----------------------------------------------------------------------------
// top_k_word_insertion_list_core
// Ranked list of the best candidate words by probability, fed one code point
// per word, with clear and slot read commands.
// ----------------------------------------------------------------------------
//  channel  | ports                    | handshake
//  ---------+--------------------------+----------------------------------
//  input    | start, busy, in_word_i   | taken when start && !busy
//  result   | result_valid_o, result_o | one cycle per result, no backpressure
//
// A push word is handled when popped; the last code point adds a
// sequential rank search that tests one rank per cycle, up to ListEntries.
// A read passes through register lookup, memory read and output register;
// a clear acts when popped. Results appear the cycle after the back end ends.
// A two-word queue lets the front accept while the back end works; busy is
// high only while the queue is full. Reset needs no clearing pass.
// ----------------------------------------------------------------------------
module top_k_word_insertion_list_core #(
  parameter int ListEntries  = tkwl_pkg::LIST_ENTRIES_DEF,
  parameter int WordCapacity = tkwl_pkg::WORD_CAPACITY_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  tkwl_pkg::in_word_t  in_word_i,
  output logic                result_valid_o,
  output tkwl_pkg::out_word_t result_o
);

  logic                head_valid;
  tkwl_pkg::cmd_word_t head;
  logic                pop;

  tkwl_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .in_word_i    (in_word_i),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  tkwl_back #(
    .ListEntries  (ListEntries),
    .WordCapacity (WordCapacity)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_i         (head),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule
